@@ rtl/core/moi_pkg.sv @@
// Shared types and constants of the Moravec interest operator.
// Used by every module of the block except moi_ram; depends on nothing else.
`timescale 1ns / 1ps

package moi_pkg;

	localparam int PIX_W = 8;
	localparam int HALF = 2;
	localparam int SPAN = 2 * HALF + 1;
	localparam int NTERM = SPAN - 1;
	localparam int NDIR = 4;

	localparam int ROW_W = 11;
	localparam int COL_W = 11;
	localparam int VAL_W = 18;
	localparam int CFG_W = 12;
	localparam int DATA_W = 32;
	localparam int ADDR_W = 4;

	localparam logic [CFG_W-1:0] LINE_WIDTH_RST = 12'd640;
	localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 12'd480;
	localparam logic [VAL_W-1:0] THRESHOLD_RST = 18'd2500;
	localparam int MIN_DIM = 5;
	localparam int MAX_HEIGHT = 2048;

	localparam int OUT_DEPTH = 16;
	localparam int CNT_W = $clog2(OUT_DEPTH + 1);

	typedef logic [PIX_W-1:0] pix_t;
	// One window column, indexed by row (0 is the oldest line).
	typedef pix_t [SPAN-1:0] column_t;
	// Whole window, indexed by column (0 is the oldest column).
	typedef column_t [SPAN-1:0] window_t;

	typedef struct packed {
		logic last;
		logic [COL_W-1:0] col;
		logic [ROW_W-1:0] row;
	} pos_t;

	typedef struct packed {
		logic last;
		logic [COL_W-1:0] col;
		logic [ROW_W-1:0] row;
		logic [VAL_W-1:0] value;
	} res_t;

	typedef enum logic [1:0] {
		REG_LINE_WIDTH = 2'd0,
		REG_FRAME_HEIGHT = 2'd1,
		REG_THRESHOLD = 2'd2
	} reg_idx_t;

endpackage

@@ rtl/core/moi_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Stand-alone; no package needed.
`timescale 1ns / 1ps

module moi_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 2048,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ rtl/core/moi_cell.sv @@
// One window column cell: holds a column of pixels and takes its neighbor's on a shift.
// Depends on moi_pkg.
`timescale 1ns / 1ps

module moi_cell import moi_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    shift,
	input  column_t col_in,
	output column_t col_out
);

	column_t col_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
		end else if (shift) begin
			col_q <= col_in;
		end
	end

	assign col_out = col_q;

endmodule

@@ rtl/core/moi_score.sv @@
// Scoring pipeline: absolute differences, squares, directional sums, minimum, threshold.
// Depends on moi_pkg.
`timescale 1ns / 1ps

module moi_score import moi_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             emit_s2,
	input  pos_t             pos_s2,
	input  window_t          win,
	input  logic [VAL_W-1:0] threshold,
	output logic             res_valid,
	output res_t             res
);

	localparam int SQ_W = 2 * PIX_W;

	logic [NDIR-1:0][NTERM-1:0][PIX_W-1:0] diff_c;
	logic [NDIR-1:0][NTERM-1:0][PIX_W-1:0] diff_s3;
	logic [NDIR-1:0][NTERM-1:0][SQ_W-1:0]  sq_s4;
	logic [NDIR-1:0][VAL_W-1:0]            sum_c;
	logic [NDIR-1:0][VAL_W-1:0]            sum_s5;
	logic [1:0][VAL_W-1:0]                 pmin_s6;
	logic [VAL_W-1:0]                      min_c;
	logic v_s3, v_s4, v_s5, v_s6;
	pos_t pos_s3, pos_s4, pos_s5, pos_s6;

	function automatic pix_t abs_diff(input pix_t a, input pix_t b);
		return (a > b) ? pix_t'(a - b) : pix_t'(b - a);
	endfunction

	// Direction 0 is vertical, 1 the down-right diagonal, 2 horizontal,
	// 3 the down-left diagonal; all run through the window center.
	always_comb begin
		for (int i = 0; i < NTERM; i++) begin
			diff_c[0][i] = abs_diff(win[HALF][i], win[HALF][i+1]);
			diff_c[1][i] = abs_diff(win[i][i], win[i+1][i+1]);
			diff_c[2][i] = abs_diff(win[i][HALF], win[i+1][HALF]);
			diff_c[3][i] = abs_diff(win[2*HALF-i][i], win[2*HALF-i-1][i+1]);
		end
	end

	// Four squares of at most 65025 sum to at most 260100, so the sum never
	// needs to saturate in 18 bits.
	always_comb begin
		for (int d = 0; d < NDIR; d++) begin
			sum_c[d] = '0;
			for (int i = 0; i < NTERM; i++) begin
				sum_c[d] = sum_c[d] + VAL_W'(sq_s4[d][i]);
			end
		end
	end

	always_ff @(posedge clk) begin
		diff_s3 <= diff_c;
		for (int d = 0; d < NDIR; d++) begin
			for (int i = 0; i < NTERM; i++) begin
				sq_s4[d][i] <= SQ_W'(diff_s3[d][i]) * SQ_W'(diff_s3[d][i]);
			end
		end
		sum_s5 <= sum_c;
		pmin_s6[0] <= (sum_s5[1] < sum_s5[0]) ? sum_s5[1] : sum_s5[0];
		pmin_s6[1] <= (sum_s5[3] < sum_s5[2]) ? sum_s5[3] : sum_s5[2];
		pos_s3 <= pos_s2;
		pos_s4 <= pos_s3;
		pos_s5 <= pos_s4;
		pos_s6 <= pos_s5;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			v_s3 <= emit_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	assign min_c = (pmin_s6[1] < pmin_s6[0]) ? pmin_s6[1] : pmin_s6[0];

	always_comb begin
		res.last = pos_s6.last;
		res.col = pos_s6.col;
		res.row = pos_s6.row;
		res.value = (min_c > threshold) ? min_c : '0;
	end

	assign res_valid = v_s6;

endmodule

@@ rtl/core/moravec_interest_operator.sv @@
// Moravec 5x5 interest operator. Throughput: one pixel per cycle while output queue
// credit keeps s_axis_tready high, set by the one-column window shift and the line
// RAM's single read and write port. The output queue holds 16 results.
// Reset (arst_n, asynchronous) clears counters, window and queue; the line RAM is not
// swept, a fill count makes never-written columns read as zero, so no clearing pass.
`timescale 1ns / 1ps

module moravec_interest_operator import moi_pkg::*; #(
	parameter int MAX_WIDTH = 2048
) (
	input  logic              clk,
	input  logic              arst_n,
	// Pixel input stream.
	input  logic              s_axis_tvalid,
	output logic              s_axis_tready,
	input  logic [7:0]        s_axis_tdata,   // [7:0] pixel
	input  logic              s_axis_tuser,   // [0] start_of_frame
	// Result output stream.
	output logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	output logic [39:0]       m_axis_tdata,   // [17:0] interest_value, [28:18] center_row,
	                                          // [39:29] center_col
	output logic              m_axis_tlast,   // last_of_frame
	// Configuration port.
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready
);

	// Column counter and line RAM address width, plus one bit to hold the width itself.
	localparam int CW = $clog2(MAX_WIDTH);
	localparam int WW = CW + 1;
	localparam int CXW = (CW > COL_W) ? CW : COL_W;
	localparam int PTR_W = $clog2(OUT_DEPTH);
	localparam int LINE_W = NTERM * PIX_W;

	// ------------------------------------------------------------------
	// Configuration registers. Writes complete in the access phase; the
	// port never waits.
	// ------------------------------------------------------------------
	logic [CFG_W-1:0] line_width_q;
	logic [CFG_W-1:0] frame_height_q;
	logic [VAL_W-1:0] threshold_q;
	reg_idx_t         reg_idx;
	logic             cfg_we;

	assign pready = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[3:2]);
	assign cfg_we = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_width_q <= LINE_WIDTH_RST;
			frame_height_q <= FRAME_HEIGHT_RST;
			threshold_q <= THRESHOLD_RST;
		end else if (cfg_we) begin
			unique case (reg_idx)
				REG_LINE_WIDTH: begin
					line_width_q <= pwdata[CFG_W-1:0];
				end
				REG_FRAME_HEIGHT: begin
					frame_height_q <= pwdata[CFG_W-1:0];
				end
				REG_THRESHOLD: begin
					threshold_q <= pwdata[VAL_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_LINE_WIDTH: begin
				prdata = DATA_W'(line_width_q);
			end
			REG_FRAME_HEIGHT: begin
				prdata = DATA_W'(frame_height_q);
			end
			REG_THRESHOLD: begin
				prdata = DATA_W'(threshold_q);
			end
			default: begin
				prdata = '0;
			end
		endcase
	end

	// ------------------------------------------------------------------
	// Effective geometry. Out-of-range register values are clamped where
	// they are used, so the counters always wrap inside the line RAM.
	// ------------------------------------------------------------------
	logic [31:0]      lw32;
	logic [31:0]      fh32;
	logic [WW-1:0]    w_eff;
	logic [CFG_W-1:0] h_eff;

	assign lw32 = 32'(line_width_q);
	assign fh32 = 32'(frame_height_q);

	always_comb begin
		if (lw32 < 32'(MIN_DIM)) begin
			w_eff = WW'(MIN_DIM);
		end else if (lw32 > 32'(MAX_WIDTH)) begin
			w_eff = WW'(MAX_WIDTH);
		end else begin
			w_eff = WW'(lw32);
		end
		if (fh32 < 32'(MIN_DIM)) begin
			h_eff = CFG_W'(MIN_DIM);
		end else if (fh32 > 32'(MAX_HEIGHT)) begin
			h_eff = CFG_W'(MAX_HEIGHT);
		end else begin
			h_eff = frame_height_q;
		end
	end

	// ------------------------------------------------------------------
	// Position counters. They hold the row and column of the next pixel;
	// a start-of-frame flag forces both to zero for the pixel it rides on.
	// ------------------------------------------------------------------
	logic             s_acc;
	logic [CW-1:0]    col_q, col_cur, col_nxt;
	logic [ROW_W-1:0] row_q, row_cur, row_nxt;
	logic [WW-1:0]    col_inc;
	logic [CFG_W-1:0] row_inc;
	logic             emit0;
	pos_t             pos0;

	assign s_acc = s_axis_tvalid && s_axis_tready;
	assign col_cur = s_axis_tuser ? '0 : col_q;
	assign row_cur = s_axis_tuser ? '0 : row_q;
	assign col_inc = WW'(col_cur) + WW'(1);
	assign row_inc = CFG_W'(row_cur) + CFG_W'(1);

	// The two-pixel border gives no result: the window is only complete once
	// both coordinates of the incoming pixel reach the window span minus one.
	assign emit0 = (row_cur >= ROW_W'(2 * HALF)) && (WW'(col_cur) >= WW'(2 * HALF));

	always_comb begin
		pos0.row = row_cur - ROW_W'(HALF);
		pos0.col = COL_W'(CXW'(col_cur) - CXW'(HALF));
		pos0.last = (CFG_W'(row_cur) == h_eff - CFG_W'(1)) &&
		            (WW'(col_cur) == w_eff - WW'(1));
		if (col_inc >= w_eff) begin
			col_nxt = '0;
			row_nxt = (row_inc >= h_eff) ? '0 : row_inc[ROW_W-1:0];
		end else begin
			col_nxt = col_inc[CW-1:0];
			row_nxt = row_cur;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (s_acc) begin
			col_q <= col_nxt;
			row_q <= row_nxt;
		end
	end

	// ------------------------------------------------------------------
	// Line RAM. Each word holds one column of the four stored lines, the
	// oldest line in the low byte. The column is read when a pixel is
	// accepted and written back one line up in the next cycle. Columns are
	// visited in order from zero, so every column below the fill count has
	// been written and every other one is read as zero, not from the RAM.
	// A read of the column being written in the same cycle takes the new
	// word from the bypass register instead of the RAM.
	// ------------------------------------------------------------------
	logic [WW-1:0]     fill_q;
	logic              v_s1;
	pix_t              pix_s1;
	logic [CW-1:0]     addr_s1;
	logic              fill_ok_s1;
	logic              byp_s1;
	logic [LINE_W-1:0] byp_data_s1;
	logic              emit_s1;
	pos_t              pos_s1;
	logic              emit_s2;
	pos_t              pos_s2;
	logic [LINE_W-1:0] ram_rdata;
	logic [LINE_W-1:0] rd_eff;
	logic [LINE_W-1:0] ram_wdata;
	logic              ram_we;
	column_t           new_col;

	moi_ram #(
		.WIDTH(LINE_W),
		.DEPTH(MAX_WIDTH)
	) u_line_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(addr_s1),
		.wdata(ram_wdata),
		.raddr(col_cur),
		.rdata(ram_rdata)
	);

	assign rd_eff = byp_s1 ? byp_data_s1 : (fill_ok_s1 ? ram_rdata : '0);
	assign ram_we = v_s1;

	always_comb begin
		for (int y = 0; y < NTERM; y++) begin
			new_col[y] = rd_eff[y*PIX_W +: PIX_W];
		end
		new_col[SPAN-1] = pix_s1;
		for (int y = 0; y < NTERM; y++) begin
			ram_wdata[y*PIX_W +: PIX_W] = new_col[y+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			v_s1 <= 1'b0;
			byp_s1 <= 1'b0;
			emit_s1 <= 1'b0;
			emit_s2 <= 1'b0;
		end else begin
			v_s1 <= s_acc;
			byp_s1 <= s_acc && v_s1 && (addr_s1 == col_cur);
			emit_s1 <= s_acc && emit0;
			emit_s2 <= emit_s1;
			if (s_acc && (col_inc > fill_q)) begin
				fill_q <= col_inc;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_acc) begin
			pix_s1 <= s_axis_tdata;
			addr_s1 <= col_cur;
			fill_ok_s1 <= WW'(col_cur) < fill_q;
			pos_s1 <= pos0;
		end
		byp_data_s1 <= ram_wdata;
		pos_s2 <= pos_s1;
	end

	// ------------------------------------------------------------------
	// Window: a chain of column cells. On every accepted pixel each cell
	// takes its newer neighbor's column and the newest cell takes the
	// column just read from the line RAM plus the incoming pixel.
	// ------------------------------------------------------------------
	window_t win;
	window_t cell_in;

	assign cell_in = {new_col, win[SPAN-1:1]};

	for (genvar x = 0; x < SPAN; x++) begin : g_cell
		moi_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.shift  (v_s1),
			.col_in (cell_in[x]),
			.col_out(win[x])
		);
	end

	// ------------------------------------------------------------------
	// Scoring pipeline; it reads the window in the cycle after the shift.
	// ------------------------------------------------------------------
	logic res_valid;
	res_t res;

	moi_score u_score (
		.clk      (clk),
		.arst_n   (arst_n),
		.emit_s2  (emit_s2),
		.pos_s2   (pos_s2),
		.win      (win),
		.threshold(threshold_q),
		.res_valid(res_valid),
		.res      (res)
	);

	// ------------------------------------------------------------------
	// Output queue with credit control. Every accepted pixel that will give
	// a result is counted as pending until it lands in the queue, so the
	// pipeline never has to stall and the queue never overflows.
	// ------------------------------------------------------------------
	res_t             fifo_mem [OUT_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] fifo_count_q;
	logic [CNT_W-1:0] pending_q;
	logic             fifo_rd;
	logic [CNT_W:0]   credit_used;
	res_t             head;

	assign fifo_rd = m_axis_tvalid && m_axis_tready;
	assign credit_used = {1'b0, fifo_count_q} + {1'b0, pending_q};
	assign s_axis_tready = credit_used < (CNT_W + 1)'(OUT_DEPTH);

	always_ff @(posedge clk) begin
		if (res_valid) begin
			fifo_mem[wr_ptr_q] <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fifo_count_q <= '0;
			pending_q <= '0;
		end else begin
			if (res_valid) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (fifo_rd) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			fifo_count_q <= fifo_count_q + CNT_W'(res_valid) - CNT_W'(fifo_rd);
			pending_q <= pending_q + CNT_W'(s_acc && emit0) - CNT_W'(res_valid);
		end
	end

	assign head = fifo_mem[rd_ptr_q];
	assign m_axis_tvalid = fifo_count_q != '0;
	assign m_axis_tdata = {head.col, head.row, head.value};
	assign m_axis_tlast = head.last;

	// ------------------------------------------------------------------
	// Assertions.
	// ------------------------------------------------------------------
	a_credit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		credit_used <= (CNT_W + 1)'(OUT_DEPTH))
		else $error("output credits exceed queue depth");

	a_queue_room: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (fifo_count_q < CNT_W'(OUT_DEPTH)))
		else $error("result written into a full output queue");

	a_line_writeback: assert property (@(posedge clk) disable iff (!arst_n)
		s_acc |=> ram_we)
		else $error("accepted pixel not written back to the line RAM");

	a_bypass_item: assert property (@(posedge clk) disable iff (!arst_n)
		byp_s1 |-> v_s1)
		else $error("line RAM bypass without an item in flight");

endmodule
